// ===== src/keyed_slot_table_core_macros.svh =====
`ifndef KEYED_SLOT_TABLE_CORE_MACROS_SVH
`define KEYED_SLOT_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define KST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed slot table check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed slot table check failed");

`endif

// ===== src/kst_pkg.sv =====
package kst_pkg;

    localparam int KEY_COUNT  = 256;
    localparam int SLOT_COUNT = 64;
    localparam int KEY_W      = $clog2(KEY_COUNT);
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_FIND   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         key;
        logic signed [31:0] data_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic               present;
        logic [5:0]         slot_used_index;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic              rel_en;
        logic [SLOT_W-1:0] rel_slot;
        logic              claim_en;
    } pool_upd_t;

    typedef struct packed {
        logic              slot_wr;
        logic              set_valid;
        logic              clr_valid;
        logic [SLOT_W-1:0] slot;
    } key_upd_t;

endpackage

// ===== src/kst_slot_pool.sv =====
module kst_slot_pool
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  kst_pkg::pool_upd_t           upd,
    output logic [kst_pkg::SLOT_W-1:0]   free_slot,
    output logic                         free_found
);

    logic [kst_pkg::SLOT_COUNT-1:0] busy_reg;
    logic [kst_pkg::SLOT_COUNT-1:0] busy_next;
    logic [kst_pkg::SLOT_COUNT-1:0] rel_mask;
    logic [kst_pkg::SLOT_COUNT-1:0] busy_eff;
    logic [kst_pkg::SLOT_COUNT-1:0] avail;
    logic [kst_pkg::SLOT_COUNT-1:0] lowest;

    always_comb
    begin
        rel_mask   = upd.rel_en ? (kst_pkg::SLOT_COUNT'(1) << upd.rel_slot) : '0;
        busy_eff   = busy_reg & ~rel_mask;
        avail      = ~busy_eff;
        lowest     = avail & (~avail + kst_pkg::SLOT_COUNT'(1));
        free_found = |avail;
        free_slot  = '0;
        for (int i = 0; i < kst_pkg::SLOT_COUNT; i++)
        begin
            if (lowest[i])
            begin
                free_slot = free_slot | kst_pkg::SLOT_W'(i);
            end
        end
        busy_next = busy_eff | (upd.claim_en ? lowest : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== src/kst_key_map.sv =====
module kst_key_map
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [kst_pkg::KEY_W-1:0]   rd_key,
    output logic [kst_pkg::SLOT_W-1:0]  rd_slot,
    output logic                        rd_valid,
    input  logic [kst_pkg::KEY_W-1:0]   wr_key,
    input  kst_pkg::key_upd_t           upd
);

    logic [kst_pkg::SLOT_W-1:0] slot_mem [kst_pkg::KEY_COUNT];
    logic [kst_pkg::SLOT_W-1:0] rd_slot_reg;
    logic [kst_pkg::KEY_COUNT-1:0] valid_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (upd.slot_wr)
        begin
            slot_mem[wr_key] <= upd.slot;
        end
        if (rd_en)
        begin
            rd_slot_reg <= slot_mem[rd_key];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd.set_valid)
            begin
                valid_reg[wr_key] <= 1'b1;
            end
            else if (upd.clr_valid)
            begin
                valid_reg[wr_key] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_key];
            end
        end
    end

    assign rd_slot  = rd_slot_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== src/kst_value_ram.sv =====
module kst_value_ram
(
    input  logic                        clk,
    input  logic                        en,
    input  logic                        we,
    input  logic [kst_pkg::SLOT_W-1:0]  addr,
    input  logic signed [31:0]          wdata,
    output logic signed [31:0]          rdata
);

    logic signed [31:0] mem [kst_pkg::SLOT_COUNT];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/keyed_slot_table_core.sv =====
// channel   direction  handshake                      payload
// request   in         start high while busy low      req (kst_pkg::req_t)
// result    out        done high for one cycle         rsp (kst_pkg::rsp_t)
//
// From accept to the next accept every item goes through S_LOOK; a get of a
// present key also goes through S_VAL for the registered value memory read.
// Each item is one key-map read, then one read-modify-write of the key map,
// slot busy bits and value memory; done shows in the cycle busy falls.
// rst_n clears the key valid bits and slot busy bits at once; no sweep.
// Results cannot be stalled; one item is in flight at a time.
module keyed_slot_table_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  kst_pkg::req_t  req,
    output logic           done,
    output kst_pkg::rsp_t  rsp
);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_VAL} state_t;

    state_t             state_reg;
    state_t             state_next;
    kst_pkg::req_t      req_reg;
    kst_pkg::req_t      req_next;
    kst_pkg::rsp_t      rsp_reg;
    kst_pkg::rsp_t      rsp_next;
    logic               done_reg;
    logic               done_next;

    logic                        accept;
    logic                        inrange;
    logic                        hit;
    logic                        add_path;
    logic [kst_pkg::SLOT_W-1:0]  rd_slot;
    logic                        rd_valid;
    logic [kst_pkg::SLOT_W-1:0]  free_slot;
    logic                        free_found;
    kst_pkg::pool_upd_t          pool_upd;
    kst_pkg::key_upd_t           key_upd;
    logic                        ram_en;
    logic                        ram_we;
    logic [kst_pkg::SLOT_W-1:0]  ram_addr;
    logic signed [31:0]          ram_rdata;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    kst_key_map u_key_map
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_key   (kst_pkg::KEY_W'(req.key)),
        .rd_slot  (rd_slot),
        .rd_valid (rd_valid),
        .wr_key   (kst_pkg::KEY_W'(req_reg.key)),
        .upd      (key_upd)
    );

    kst_slot_pool u_slot_pool
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (pool_upd),
        .free_slot  (free_slot),
        .free_found (free_found)
    );

    kst_value_ram u_value_ram
    (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (req_reg.data_in),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        inrange  = (32'(req_reg.key) < kst_pkg::KEY_COUNT);
        hit      = inrange && rd_valid;
        add_path = inrange && ((req_reg.mode == kst_pkg::MODE_ADD) ||
                               ((req_reg.mode == kst_pkg::MODE_SET) && !hit));

        state_next = state_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        pool_upd   = '0;
        key_upd    = '0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = rd_slot;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                rsp_next                 = '0;
                rsp_next.present         = hit;
                rsp_next.slot_used_index = hit ? 6'(rd_slot) : 6'd0;
                state_next               = S_IDLE;
                done_next                = 1'b1;
                pool_upd.rel_slot        = rd_slot;

                if (add_path)
                begin
                    // drop the old slot before picking the lowest free one
                    pool_upd.rel_en   = hit;
                    key_upd.clr_valid = hit;
                    if (free_found)
                    begin
                        pool_upd.claim_en        = 1'b1;
                        ram_en                   = 1'b1;
                        ram_we                   = 1'b1;
                        ram_addr                 = free_slot;
                        key_upd.slot_wr          = 1'b1;
                        key_upd.set_valid        = 1'b1;
                        key_upd.slot             = free_slot;
                        rsp_next.present         = 1'b1;
                        rsp_next.slot_used_index = 6'(free_slot);
                    end
                    else
                    begin
                        rsp_next.present         = 1'b0;
                        rsp_next.slot_used_index = 6'd0;
                        rsp_next.status          = kst_pkg::ST_FULL;
                    end
                end
                else
                begin
                    unique case (req_reg.mode)
                        kst_pkg::MODE_ADD:
                        begin
                            rsp_next.status = kst_pkg::ST_FULL;
                        end
                        kst_pkg::MODE_SET:
                        begin
                            if (hit)
                            begin
                                ram_en = 1'b1;
                                ram_we = 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = kst_pkg::ST_FULL;
                            end
                        end
                        kst_pkg::MODE_REMOVE:
                        begin
                            if (hit)
                            begin
                                pool_upd.rel_en          = 1'b1;
                                key_upd.clr_valid        = 1'b1;
                                rsp_next.present         = 1'b0;
                                rsp_next.slot_used_index = 6'd0;
                            end
                            else
                            begin
                                rsp_next.status = kst_pkg::ST_ABSENT;
                            end
                        end
                        kst_pkg::MODE_GET:
                        begin
                            if (hit)
                            begin
                                ram_en     = 1'b1;
                                done_next  = 1'b0;
                                state_next = S_VAL;
                            end
                            else
                            begin
                                rsp_next.status = kst_pkg::ST_ABSENT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_VAL:
            begin
                rsp_next.data_out = ram_rdata;
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= '0;
            rsp_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            rsp_reg   <= rsp_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== src/kst_checker.sv =====
`include "keyed_slot_table_core_macros.svh"

module kst_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input kst_pkg::rsp_t rsp
);

    logic accept;

    assign accept = start && !busy;

    `KST_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `KST_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !done)
    `KST_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `KST_ASSERT_NOW(a_fail_absent, clk, rst_n, done && (rsp.status != kst_pkg::ST_OK),
        !rsp.present && (rsp.slot_used_index == 6'd0))
    `KST_ASSERT_NOW(a_data_needs_key, clk, rst_n, done && !rsp.present,
        rsp.data_out == 32'sd0)

endmodule

bind keyed_slot_table_core kst_checker u_kst_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
